@@ design/cc20_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and round functions for the ChaCha20 block core.
// No dependencies; imported by chacha20_block_function_core.
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef word_t [7:0] key_t;
  typedef word_t [2:0] nonce_t;

  localparam int unsigned NUM_WORDS = 16;
  localparam logic [3:0] LAST_IDX = 4'd15;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_0_63    = 3'd0;
  localparam logic [2:0] CFG_KEY_64_127  = 3'd1;
  localparam logic [2:0] CFG_KEY_128_191 = 3'd2;
  localparam logic [2:0] CFG_KEY_192_255 = 3'd3;
  localparam logic [2:0] CFG_NONCE_0_63  = 3'd4;
  localparam logic [2:0] CFG_NONCE_64_95 = 3'd5;

  function automatic state_t build_state(key_t key, nonce_t nonce, word_t cnt);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[11:4] = key;
    s[12] = cnt;
    s[15:13] = nonce;
    return s;
  endfunction

  // One half of a quarter round on all four quarters of a column or diagonal round.
  // First half rotates by 16 and 12, second half by 8 and 7.
  function automatic state_t round_step(state_t x, logic diag, logic second);
    state_t y;
    logic [1:0] qb;
    logic [1:0] ob;
    logic [1:0] oc;
    logic [1:0] od;
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t t;
    y = x;
    for (int q = 0; q < 4; q++) begin
      qb = 2'(q);
      ob = qb + {1'b0, diag};
      oc = qb + {diag, 1'b0};
      od = qb + {diag, diag};
      a = x[{2'b00, qb}];
      b = x[{2'b01, ob}];
      c = x[{2'b10, oc}];
      d = x[{2'b11, od}];
      a = a + b;
      t = d ^ a;
      d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
      c = c + d;
      t = b ^ c;
      b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
      y[{2'b00, qb}] = a;
      y[{2'b01, ob}] = b;
      y[{2'b10, oc}] = c;
      y[{2'b11, od}] = d;
    end
    return y;
  endfunction

endpackage

@@ design/chacha20_block_function_core.sv @@
`timescale 1ns / 1ps
// ChaCha20 block function core: fully pipelined rounds plus a word serializer.
// Depends on cc20_pkg (types, constants, round step function).
//
//  Channel  Ports                                        Handshake
//  -------  -------------------------------------------  ---------------------------
//  input    in_block_counter                             start high, busy low
//  result   out_word_index, out_keystream_word,          out_valid high with each word
//           out_last_word
//  config   cfg_index, cfg_data                          cfg_we high, no wait
//
// Each double round is four register stages (half a quarter round each), so a counter
// passes from data_r[0] through the round stages into the serializer registers; each
// word is then registered in out_word_r. The serializer emits 16 words, one per cycle,
// so the single result port, not the rounds, sets the sustained block rate.
// busy rises only when a finished block waits on the serializer; the whole pipe then
// holds. Reset (rst_n low, synchronous) clears valid bits and configuration to zero.
module chacha20_block_function_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cc20_pkg::word_t   in_block_counter,
  output logic              out_valid,
  output logic [3:0]        out_word_index,
  output cc20_pkg::word_t   out_keystream_word,
  output logic              out_last_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import cc20_pkg::*;

  localparam int unsigned NSTG = 4 * DOUBLE_ROUNDS;

  key_t   key_r;
  nonce_t nonce_r;

  state_t data_r [0:NSTG];
  word_t  cnt_r  [0:NSTG];
  logic   vld_r  [0:NSTG];

  state_t     ser_data_r;
  word_t      ser_cnt_r;
  logic       ser_active_r;
  logic [3:0] ser_idx_r;

  logic       out_valid_r;
  logic [3:0] out_idx_r;
  word_t      out_word_r;
  logic       out_last_r;

  logic   stall;
  logic   adv;
  logic   accept;
  state_t init_state;
  state_t ser_init;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_0_63:    key_r[1:0] <= cfg_data;
        CFG_KEY_64_127:  key_r[3:2] <= cfg_data;
        CFG_KEY_128_191: key_r[5:4] <= cfg_data;
        CFG_KEY_192_255: key_r[7:6] <= cfg_data;
        CFG_NONCE_0_63:  nonce_r[1:0] <= cfg_data;
        CFG_NONCE_64_95: nonce_r[2] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Hold the whole pipe while a finished block waits on a busy serializer
  assign stall  = vld_r[NSTG] && ser_active_r && (ser_idx_r != LAST_IDX);
  assign adv    = !stall;
  assign busy   = stall;
  assign accept = start && !busy;

  assign init_state = build_state(key_r, nonce_r, in_block_counter);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r[0] <= init_state;
      cnt_r[0]  <= in_block_counter;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_stage
    localparam logic DIAG   = 1'(((s - 1) / 2) % 2);
    localparam logic SECOND = 1'((s - 1) % 2);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        data_r[s] <= round_step(data_r[s-1], DIAG, SECOND);
        cnt_r[s]  <= cnt_r[s-1];
      end
    end
  end

  // Serializer: load a finished block, then step through its 16 words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_active_r <= 1'b0;
      ser_idx_r    <= '0;
    end else if (adv && vld_r[NSTG]) begin
      ser_active_r <= 1'b1;
      ser_idx_r    <= '0;
    end else if (ser_active_r) begin
      ser_active_r <= (ser_idx_r != LAST_IDX);
      ser_idx_r    <= ser_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NSTG]) begin
      ser_data_r <= data_r[NSTG];
      ser_cnt_r  <= cnt_r[NSTG];
    end
  end

  assign ser_init = build_state(key_r, nonce_r, ser_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ser_active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= ser_idx_r;
    out_word_r <= ser_data_r[ser_idx_r] + ser_init[ser_idx_r];
    out_last_r <= (ser_idx_r == LAST_IDX);
  end

  assign out_valid          = out_valid_r;
  assign out_word_index     = out_idx_r;
  assign out_keystream_word = out_word_r;
  assign out_last_word      = out_valid_r && out_last_r;

`ifndef SYNTHESIS
  a_last_on_final_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> (out_valid && (out_word_index == LAST_IDX)))
    else $error("last flag on a word other than the final one");

  a_words_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word_index != LAST_IDX)) |=>
      (out_valid && (out_word_index == $past(out_word_index) + 4'd1)))
    else $error("keystream words not contiguous within a block");

  a_busy_only_on_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (vld_r[NSTG] && ser_active_r))
    else $error("busy without a finished block waiting");

  a_stall_keeps_tail: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> vld_r[NSTG])
    else $error("finished block dropped during a stall");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chacha20_block_function_core: directed and random block counters
// under several key/nonce settings, each block predicted locally and checked word by word.
// Depends on cc20_pkg and the core RTL.
module testbench;
  import cc20_pkg::*;

  localparam int unsigned ROUNDS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4 * ROUNDS + 20;
  localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [2:0] CFG_UNUSED_7 = 3'd7;

  typedef struct {
    logic [3:0] idx;
    word_t      word;
    logic       last;
  } ks_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  word_t       in_block_counter = '0;
  logic        out_valid;
  logic [3:0]  out_word_index;
  word_t       out_keystream_word;
  logic        out_last_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  word_t    key_w [8];
  word_t    nonce_w [3];
  word_t    counters_to_send [$];
  ks_word_t keystream_expected [$];
  int       sender_idle_pct = 0;
  int       error_count = 0;
  int       cycle_count = 0;

  chacha20_block_function_core #(.DOUBLE_ROUNDS(ROUNDS)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_block_counter   (in_block_counter),
    .out_valid          (out_valid),
    .out_word_index     (out_word_index),
    .out_keystream_word (out_keystream_word),
    .out_last_word      (out_last_word),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t mix_quarter(state_t x, int a, int b, int c, int d);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
    return x;
  endfunction

  // Compute the 16 keystream words for one counter and queue them in order.
  function automatic void chacha_keystream_block(word_t counter);
    state_t   init;
    state_t   work;
    ks_word_t w;
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
    init[12] = counter;
    for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
    work = init;
    for (int r = 0; r < ROUNDS; r++) begin
      work = mix_quarter(work, 0, 4, 8, 12);
      work = mix_quarter(work, 1, 5, 9, 13);
      work = mix_quarter(work, 2, 6, 10, 14);
      work = mix_quarter(work, 3, 7, 11, 15);
      work = mix_quarter(work, 0, 5, 10, 15);
      work = mix_quarter(work, 1, 6, 11, 12);
      work = mix_quarter(work, 2, 7, 8, 13);
      work = mix_quarter(work, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      w.idx = 4'(i);
      w.word = work[i] + init[i];
      w.last = (i == 15);
      keystream_expected.push_back(w);
    end
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("MISMATCH @%0t %s: got %08h expected %08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: hold start until the transaction is taken, then pick the next one or idle.
  always @(posedge clk) begin : drive_counters
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        chacha_keystream_block(in_block_counter);
        void'(counters_to_send.pop_front());
      end
      if (start && busy) go = 1'b1;
      else go = (counters_to_send.size() > 0) && (int'($urandom_range(99)) >= sender_idle_pct);
      start <= go;
      if (go) in_block_counter <= counters_to_send[0];
    end
  end

  always @(posedge clk) begin : check_words
    ks_word_t want;
    if (rst_n && out_valid) begin
      if (keystream_expected.size() == 0) begin
        report_mismatch("unexpected result", out_keystream_word, '0);
      end else begin
        want = keystream_expected.pop_front();
        if (out_word_index !== want.idx)
          report_mismatch("word_index", 32'(out_word_index), 32'(want.idx));
        if (out_keystream_word !== want.word)
          report_mismatch($sformatf("keystream_word %0d", want.idx), out_keystream_word,
                          want.word);
        if (out_last_word !== want.last)
          report_mismatch("last_word", 32'(out_last_word), 32'(want.last));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_KEY_0_63, CFG_KEY_64_127, CFG_KEY_128_191, CFG_KEY_192_255: begin
        key_w[2 * idx] = data[31:0];
        key_w[2 * idx + 1] = data[63:32];
      end
      CFG_NONCE_0_63: begin
        nonce_w[0] = data[31:0];
        nonce_w[1] = data[63:32];
      end
      CFG_NONCE_64_95: nonce_w[2] = data[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every queued counter is taken and every word has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (counters_to_send.size() != 0 || start || keystream_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_cfg_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_config();
    write_reg(CFG_KEY_0_63, pick_cfg_value());
    write_reg(CFG_KEY_64_127, pick_cfg_value());
    write_reg(CFG_KEY_128_191, pick_cfg_value());
    write_reg(CFG_KEY_192_255, pick_cfg_value());
    write_reg(CFG_NONCE_0_63, pick_cfg_value());
    write_reg(CFG_NONCE_64_95, pick_cfg_value());
    if ($urandom_range(1)) write_reg(CFG_UNUSED_6, {$urandom, $urandom});
    if ($urandom_range(1)) write_reg(CFG_UNUSED_7, {$urandom, $urandom});
  endtask

  task automatic random_phase(int n, int idle);
    word_t c;
    @(negedge clk);
    sender_idle_pct = idle;
    c = $urandom;
    for (int i = 0; i < n; i++) begin
      // mostly consecutive runs as a stream cipher would use, some jumps and wraps
      case ($urandom_range(9))
        0, 1: c = $urandom;
        2: c = 32'hFFFFFFFF - $urandom_range(3);
        3: c = $urandom_range(3);
        default: c = c + 1;
      endcase
      counters_to_send.push_back(c);
    end
    wait_idle();
  endtask

  task automatic directed_phase(word_t vals[$]);
    @(negedge clk);
    sender_idle_pct = 0;
    foreach (vals[i]) counters_to_send.push_back(vals[i]);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_w[i] = '0;
    for (int i = 0; i < 3; i++) nonce_w[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: all-zero key and nonce
    directed_phase('{32'h0, 32'hFFFFFFFF, 32'h1});

    // all-ones key and nonce, stray high bits on nonce word 2, ignored indexes
    for (int i = 0; i < 6; i++) write_reg(3'(i), '1);
    write_reg(CFG_UNUSED_6, 64'h0);
    write_reg(CFG_UNUSED_7, 64'h0);
    directed_phase('{32'h0, 32'h80000000, 32'h7FFFFFFF});

    // standard test vector key and nonce
    write_reg(CFG_KEY_0_63, 64'h07060504_03020100);
    write_reg(CFG_KEY_64_127, 64'h0f0e0d0c_0b0a0908);
    write_reg(CFG_KEY_128_191, 64'h17161514_13121110);
    write_reg(CFG_KEY_192_255, 64'h1f1e1d1c_1b1a1918);
    write_reg(CFG_NONCE_0_63, 64'h4a000000_09000000);
    write_reg(CFG_NONCE_64_95, 64'hDEADBEEF_00000000);
    directed_phase('{32'h1, 32'h0, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF});

    random_config();
    random_phase(100, 0);
    random_config();
    random_phase(100, 86);
    random_config();
    random_phase(100, 0);
    random_config();
    random_phase(100, 30);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/cc20_pkg.sv
design/chacha20_block_function_core.sv
dv/testbench.sv
